// File: hw/rtl/brcfz_pkg.sv
// Shared constants, command codes and the inter-cell word type for the bitmap allocator.
`default_nettype none

package brcfz_pkg;

  localparam int BITS_DEF = 256;  // default bitmap size
  localparam int CELL_W   = 8;    // bitmap bits held by one cell
  localparam int IDX_W    = 8;
  localparam int END_W    = 9;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLAIM = 2'd3;

  // One command traveling down the chain, with the result built up so far.
  // found doubles as "already claimed" for cells further down.
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [END_W-1:0] range_end;
    logic             bit_value;
    logic             read_bit;
    logic             found;
    logic [IDX_W-1:0] position;
  } brcfz_wave_t;

endpackage

`default_nettype wire

// File: hw/rtl/brcfz_cmd_if.sv
// Command channel: valid/ready with the command word payload.
`default_nettype none

interface brcfz_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [brcfz_pkg::CMD_W-1:0] command;
  logic [brcfz_pkg::IDX_W-1:0] index;
  logic [brcfz_pkg::END_W-1:0] range_end;
  logic                        bit_value;

  modport source (output valid, command, index, range_end, bit_value, input ready);
  modport sink   (input valid, command, index, range_end, bit_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/brcfz_rsp_if.sv
// Result channel: valid/ready with the result word payload.
`default_nettype none

interface brcfz_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        read_bit;
  logic                        found;
  logic [brcfz_pkg::IDX_W-1:0] position;

  modport source (output valid, read_bit, found, position, input ready);
  modport sink   (input valid, read_bit, found, position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/brcfz_cell.sv
// One chain cell: holds CELL_W bitmap bits and applies each passing command to them.
`default_nettype none

module brcfz_cell #(
  parameter int BITS    = brcfz_pkg::BITS_DEF,
  parameter int CELL_ID = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire brcfz_pkg::brcfz_wave_t wave_in,
  output brcfz_pkg::brcfz_wave_t      wave_out
);
  import brcfz_pkg::*;

  localparam int NCELL  = (BITS + CELL_W - 1) / CELL_W;
  localparam int SPAN_W = $clog2(NCELL * CELL_W + 1);
  localparam int POS_W  = (SPAN_W > END_W) ? SPAN_W : END_W;
  localparam int BASE   = CELL_ID * CELL_W;

  logic [CELL_W-1:0] bits_r, bits_nxt;
  brcfz_wave_t       wave_r, wave_nxt;
  logic [POS_W-1:0]  pos, idx_x, end_x;
  logic              live;

  always_comb begin
    bits_nxt = bits_r;
    wave_nxt = wave_in;
    idx_x    = POS_W'(wave_in.index);
    end_x    = POS_W'(wave_in.range_end);
    pos      = '0;
    live     = 1'b0;
    for (int j = 0; j < CELL_W; j++) begin
      pos  = POS_W'(BASE + j);
      live = wave_in.valid && (pos < POS_W'(BITS));  // padding bits past BITS never act
      unique case (wave_in.command)
        CMD_READ: begin
          if (live && pos == idx_x) wave_nxt.read_bit = bits_r[j];
        end
        CMD_WRITE: begin
          if (live && pos == idx_x) bits_nxt[j] = wave_in.bit_value;
        end
        CMD_CLEAR: begin
          if (live && pos >= idx_x && pos < end_x) bits_nxt[j] = 1'b0;
        end
        CMD_CLAIM: begin
          // first zero at or after index, unless an earlier bit already took it
          if (live && !wave_nxt.found && pos >= idx_x && !bits_r[j]) begin
            bits_nxt[j]       = 1'b1;
            wave_nxt.found    = 1'b1;
            wave_nxt.position = pos[IDX_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
      bits_r <= '0;
    end else if (adv) begin
      wave_r <= wave_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_range_clear_find_zero_core.sv
// Bitmap allocator top level: command chain of cells and result handshake.
`default_nettype none

// Bitmap of BITS bits, all zero after reset, with read, write, range clear and
// claim-first-zero-at-or-after-index commands. The bitmap is split over a row of
// ceil(BITS/8) cells, 8 bits each; a command word enters the first cell on
// acceptance and moves one cell per cycle whenever the chain moves, each cell
// applying it to its own bits, so a claim finds the lowest free bit as the word
// sweeps upward. The word leaving the last cell is caught in an output register,
// which drives the result. Since every cell sees commands in order, a new word is
// accepted in every cycle the chain moves, one word per cycle sustained. A result
// waiting in the output register does not hold the input by itself; the whole
// chain stalls only while a word at the chain end cannot move into the output
// register because the result already there is held by a low out_rsp.ready.
module bitmap_range_clear_find_zero_core #(
  parameter int BITS = brcfz_pkg::BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  brcfz_cmd_if.sink   in_cmd,
  brcfz_rsp_if.source out_rsp
);
  import brcfz_pkg::*;

  localparam int NCELL = (BITS + CELL_W - 1) / CELL_W;

  brcfz_wave_t      chain [NCELL+1];
  logic             adv;
  logic             out_valid_r, out_valid_nxt;
  logic             out_read_bit_r, out_read_bit_nxt;
  logic             out_found_r, out_found_nxt;
  logic [IDX_W-1:0] out_position_r, out_position_nxt;

  // chain moves when its end is a bubble or the output register can take the word
  assign adv = !chain[NCELL].valid || !out_valid_r || out_rsp.ready;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = in_cmd.valid;
    chain[0].command   = in_cmd.command;
    chain[0].index     = in_cmd.index;
    chain[0].range_end = in_cmd.range_end;
    chain[0].bit_value = in_cmd.bit_value;
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    brcfz_cell #(
      .BITS    (BITS),
      .CELL_ID (c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .wave_in  (chain[c]),
      .wave_out (chain[c+1])
    );
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_read_bit_nxt = out_read_bit_r;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;
    if (adv && chain[NCELL].valid) begin
      out_valid_nxt    = 1'b1;
      out_read_bit_nxt = chain[NCELL].read_bit;
      out_found_nxt    = chain[NCELL].found;
      out_position_nxt = chain[NCELL].position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      out_read_bit_r <= 1'b0;
      out_found_r    <= 1'b0;
      out_position_r <= '0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      out_read_bit_r <= out_read_bit_nxt;
      out_found_r    <= out_found_nxt;
      out_position_r <= out_position_nxt;
    end
  end

  assign in_cmd.ready     = adv;
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.read_bit = out_read_bit_r;
  assign out_rsp.found    = out_found_r;
  assign out_rsp.position = out_position_r;

endmodule

`default_nettype wire

// File: tb/brcfz_checker.sv
// Scoreboard for the bitmap allocator: shadow bitmap, reply prediction and comparison.
module brcfz_checker
  import brcfz_pkg::*;
#(
  parameter int BITS = BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_index,
  input  logic [END_W-1:0] in_range_end,
  input  logic             in_bit_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_read_bit,
  input  logic             out_found,
  input  logic [IDX_W-1:0] out_position,
  output int               mismatches,
  output int               owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             read_bit;
    logic             found;
    logic [IDX_W-1:0] position;
  } bitmap_reply_t;

  logic [BITS-1:0] shadow_map;
  bitmap_reply_t   owed_replies[$];
  int              fails = 0;

  initial begin
    mismatches = 0;
    owed       = 0;
  end

  // Applies one command word to the shadow bitmap and returns the reply it earns.
  function automatic bitmap_reply_t run_bitmap_cmd(input logic [CMD_W-1:0] cmd,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [END_W-1:0] rend,
                                                   input logic             val);
    bitmap_reply_t r;
    int            stop;
    int            start;
    r     = '0;
    start = int'(idx);
    stop  = (int'(rend) > BITS) ? BITS : int'(rend);
    case (cmd)
      CMD_READ: begin
        if (start < BITS) r.read_bit = shadow_map[start];
      end
      CMD_WRITE: begin
        if (start < BITS) shadow_map[start] = val;
      end
      CMD_CLEAR: begin
        for (int k = start; k < stop; k++) shadow_map[k] = 1'b0;
      end
      default: begin
        for (int k = start; k < BITS; k++) begin
          if (!r.found && !shadow_map[k]) begin
            shadow_map[k] = 1'b1;
            r.found       = 1'b1;
            r.position    = IDX_W'(k);
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    bitmap_reply_t got;
    bitmap_reply_t want;
    if (!rst_n) begin
      shadow_map = '0;
      owed_replies.delete();
    end else begin
      // retire before predict: a reply never belongs to the word accepted at the same edge
      if (out_valid && out_ready) begin
        got.read_bit = out_read_bit;
        got.found    = out_found;
        got.position = out_position;
        if (owed_replies.size() == 0) begin
          $error("reply word with no command outstanding");
          fails++;
        end else begin
          want = owed_replies.pop_front();
          if (got.read_bit !== want.read_bit) begin
            $error("read_bit: expected %0d, actual %0d", want.read_bit, got.read_bit);
            fails++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            fails++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            fails++;
          end
        end
      end
      if (in_valid && in_ready)
        owed_replies.push_back(run_bitmap_cmd(in_command, in_index, in_range_end,
                                              in_bit_value));
    end
    mismatches <= fails;
    owed       <= owed_replies.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the bitmap allocator testbench: clock, reset, command stimulus, reply pacing, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brcfz_pkg::*;

  localparam int BITS        = BITS_DEF;
  localparam int CHAIN_DEPTH = (BITS + 7) / 8;
  localparam int RAND_WORDS  = 1530;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  int   chk_fails;
  int   chk_owed;
  int   burst_left = 0;

  brcfz_cmd_if cmd_bus ();
  brcfz_rsp_if rsp_bus ();

  bitmap_range_clear_find_zero_core #(
    .BITS(BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_bus),
    .out_rsp(rsp_bus)
  );

  brcfz_checker #(
    .BITS(BITS)
  ) i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd_bus.valid),
    .in_ready    (cmd_bus.ready),
    .in_command  (cmd_bus.command),
    .in_index    (cmd_bus.index),
    .in_range_end(cmd_bus.range_end),
    .in_bit_value(cmd_bus.bit_value),
    .out_valid   (rsp_bus.valid),
    .out_ready   (rsp_bus.ready),
    .out_read_bit(rsp_bus.read_bit),
    .out_found   (rsp_bus.found),
    .out_position(rsp_bus.position),
    .mismatches  (chk_fails),
    .owed        (chk_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Idle cycles before the next command word; mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 3) begin
      burst_left = $urandom_range(40, 120);
      return 0;
    end
    if (roll < 6) return $urandom_range(15, 60);
    if (roll < 25) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic put_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [END_W-1:0] rend, input logic val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= cmd;
    cmd_bus.index     <= idx;
    cmd_bus.range_end <= rend;
    cmd_bus.bit_value <= val;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Sender goes quiet until every reply has come back.
  task automatic drain_replies();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (chk_owed != 0);
  endtask

  task automatic directed_words();
    put_word(CMD_READ,  8'd0,   9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd0,   9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd0,   9'd0,   1'b1);
    put_word(CMD_WRITE, 8'd255, 9'd0,   1'b1);
    put_word(CMD_READ,  8'd255, 9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd250, 9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd254, 9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd255, 9'd0,   1'b0);  // top bit taken: nothing found
    put_word(CMD_WRITE, 8'd255, 9'd0,   1'b0);
    put_word(CMD_READ,  8'd255, 9'd0,   1'b0);
    put_word(CMD_CLEAR, 8'd0,   9'd0,   1'b0);  // empty range
    put_word(CMD_CLEAR, 8'd10,  9'd5,   1'b0);  // reversed range
    put_word(CMD_CLEAR, 8'd255, 9'd255, 1'b1);
    put_word(CMD_READ,  8'd1,   9'd511, 1'b1);
    put_word(CMD_CLEAR, 8'd0,   9'd511, 1'b0);  // end saturates to the map size
    put_word(CMD_READ,  8'd1,   9'd0,   1'b0);
    put_word(CMD_WRITE, 8'd128, 9'd0,   1'b1);
    put_word(CMD_WRITE, 8'd0,   9'd0,   1'b1);
    put_word(CMD_WRITE, 8'd255, 9'd0,   1'b1);
    put_word(CMD_CLEAR, 8'd1,   9'd256, 1'b0);
    put_word(CMD_READ,  8'd0,   9'd0,   1'b0);
    put_word(CMD_READ,  8'd128, 9'd0,   1'b0);
    put_word(CMD_READ,  8'd255, 9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd0,   9'd0,   1'b0);
    put_word(CMD_CLAIM, 8'd255, 9'd300, 1'b1);
  endtask

  task automatic random_word();
    int              roll;
    logic [IDX_W-1:0] idx;
    logic [END_W-1:0] rend;
    int              span;
    roll = $urandom_range(99);
    idx  = IDX_W'($urandom_range(255));
    rend = END_W'($urandom_range(511));
    if (roll < 22) begin
      put_word(CMD_READ, idx, rend, 1'($urandom_range(1)));
    end else if (roll < 42) begin
      put_word(CMD_WRITE, idx, rend, 1'($urandom_range(1)));
    end else if (roll < 57) begin
      span = $urandom_range(99);
      if (span < 60)
        rend = END_W'(int'(idx) + $urandom_range(0, 16));
      else if (span < 75)
        rend = 9'd256;
      put_word(CMD_CLEAR, idx, rend, 1'($urandom_range(1)));
    end else begin
      // claims from low indexes walk far up the map
      if ($urandom_range(1)) idx = IDX_W'($urandom_range(31));
      put_word(CMD_CLAIM, idx, rend, 1'($urandom_range(1)));
    end
  endtask

  // Reply side pacing, with one long hold-off that backs the chain up into the sender.
  initial begin
    int seen;
    int stall;
    int free_run;
    int roll;
    bit held_off;
    seen     = 0;
    stall    = 0;
    free_run = 0;
    held_off = 1'b0;
    rsp_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) seen++;
      if (!held_off && seen >= 500) begin
        held_off = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
        rsp_bus.ready <= 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        rsp_bus.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          free_run = $urandom_range(50, 200);
          rsp_bus.ready <= 1'b1;
        end else if (roll < 6) begin
          stall = $urandom_range(15, 60);
          rsp_bus.ready <= 1'b0;
        end else if (roll < 26) begin
          stall = $urandom_range(0, 2);
          rsp_bus.ready <= 1'b0;
        end else begin
          rsp_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.command   <= CMD_READ;
    cmd_bus.index     <= '0;
    cmd_bus.range_end <= '0;
    cmd_bus.bit_value <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();
    drain_replies();
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 800) drain_replies();
      random_word();
    end
    cmd_bus.valid <= 1'b0;

    do @(posedge clk); while (chk_owed != 0);
    // nothing owed; keep watching for stray reply words
    repeat (3 * CHAIN_DEPTH) @(posedge clk);
    if (chk_fails == 0 && chk_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/brcfz_pkg.sv
hw/rtl/brcfz_cmd_if.sv
hw/rtl/brcfz_rsp_if.sv
hw/rtl/brcfz_cell.sv
hw/rtl/bitmap_range_clear_find_zero_core.sv
tb/brcfz_checker.sv
tb/tb_top.sv
